// ----- hdl/tes_pkg.sv -----
// package with shared types and constants for the tracked entity slot table
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned VAL_W         = 31;
  localparam int unsigned IDX_OUT_W     = 4;
  localparam int unsigned CNT_OUT_W     = 5;
  localparam int unsigned STATUS_W      = 3;
  localparam logic [VAL_W-1:0] DIST_MAX = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_MEMORIZE = 2'd0,
    ACT_FORGET   = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_QUERY    = 2'd3
  } action_e;

  localparam logic [1:0] SENSE_VISUAL = 2'd0;
  localparam logic [1:0] SENSE_SOUND  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FORGOTTEN = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_FOUND     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_OUT  = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
  } tes_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/tes_ctrl.sv -----
// controller state machine sequencing one request through the slot table
`timescale 1ns / 1ps
`default_nettype none
module tes_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tes_pkg::tes_cmd_t      cmd_o
);
  import tes_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_READ;
      S_READ: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_READ: cmd_o.read = 1'b1;
      S_OUT:  out_valid_o = 1'b1;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tes_datapath.sv -----
// datapath: request register, key match, slot flags and record memories
`timescale 1ns / 1ps
`default_nettype none
module tes_datapath #(
  parameter int unsigned NUM_SLOTS = tes_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tes_pkg::tes_cmd_t                 cmd_i,
  input  wire logic [1:0]                        action_i,
  input  wire logic [tes_pkg::KEY_W-1:0]         entity_id_i,
  input  wire logic [1:0]                        sense_kind_i,
  input  wire logic [3*tes_pkg::COORD_W-1:0]     pos_i,
  input  wire logic [3*tes_pkg::COORD_W-1:0]     vel_i,
  input  wire logic [tes_pkg::VAL_W-1:0]         range_dist_i,
  input  wire logic [tes_pkg::VAL_W-1:0]         now_time_i,
  output logic [tes_pkg::STATUS_W-1:0]           status_o,
  output logic [tes_pkg::IDX_OUT_W-1:0]          slot_index_o,
  output logic [tes_pkg::CNT_OUT_W-1:0]          occupied_count_o,
  output logic                                   is_visible_o,
  output logic [tes_pkg::VAL_W-1:0]              seen_time_o,
  output logic [tes_pkg::VAL_W-1:0]              heard_time_o,
  output logic [tes_pkg::VAL_W-1:0]              check_time_o,
  output logic [tes_pkg::VAL_W-1:0]              slot_dist_o
);
  import tes_pkg::*;

  localparam int unsigned IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(NUM_SLOTS + 1);

  // request register
  action_e                  act_q;
  logic [KEY_W-1:0]         key_q;
  logic [1:0]               sense_q;
  logic [3*COORD_W-1:0]     pos_q;
  logic [3*COORD_W-1:0]     vel_q;
  logic [VAL_W-1:0]         dist_q;
  logic [VAL_W-1:0]         now_q;

  // slot flags and keys
  logic [NUM_SLOTS-1:0]     used_q, used_d;
  logic [KEY_W-1:0]         slot_key_q [NUM_SLOTS];
  logic [CNTW-1:0]          count_q, count_d;
  status_e                  status_q, status_d;
  logic                     has_slot_q, has_slot_d;
  logic [IDXW-1:0]          idx_q, idx_d;

  // record memories
  logic [3*COORD_W-1:0]     pos_mem   [NUM_SLOTS];
  logic [3*COORD_W-1:0]     vel_mem   [NUM_SLOTS];
  logic [VAL_W-1:0]         dist_mem  [NUM_SLOTS];
  logic [VAL_W-1:0]         seen_mem  [NUM_SLOTS];
  logic [VAL_W-1:0]         heard_mem [NUM_SLOTS];
  logic [VAL_W-1:0]         check_mem [NUM_SLOTS];
  logic                     vis_mem   [NUM_SLOTS];

  logic [VAL_W-1:0]         rd_dist_q, rd_seen_q, rd_heard_q, rd_check_q;
  logic                     rd_vis_q;

  logic                     hit_any, free_any;
  logic [IDXW-1:0]          hit_idx, free_idx;
  logic                     wr_en, wr_ins, key_we;
  logic [IDXW-1:0]          wr_idx;
  logic                     is_visual, is_sound;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_e'(action_i);
      key_q   <= entity_id_i;
      sense_q <= sense_kind_i;
      pos_q   <= pos_i;
      vel_q   <= vel_i;
      dist_q  <= range_dist_i;
      now_q   <= now_time_i;
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (used_q[s] && (slot_key_q[s] == key_q)) begin
        hit_any = 1'b1;
        hit_idx = IDXW'(s);
      end
      if (!used_q[s]) begin
        free_any = 1'b1;
        free_idx = IDXW'(s);
      end
    end
  end

  always_comb begin
    used_d     = used_q;
    count_d    = count_q;
    status_d   = status_q;
    has_slot_d = has_slot_q;
    idx_d      = idx_q;
    wr_en      = 1'b0;
    wr_ins     = 1'b0;
    key_we     = 1'b0;
    wr_idx     = hit_any ? hit_idx : free_idx;
    if (cmd_i.exec) begin
      case (act_q)
        ACT_MEMORIZE: begin
          if (hit_any) begin
            wr_en      = 1'b1;
            status_d   = ST_UPDATED;
            has_slot_d = 1'b1;
            idx_d      = hit_idx;
          end else if (free_any) begin
            wr_en          = 1'b1;
            wr_ins         = 1'b1;
            key_we         = 1'b1;
            used_d[free_idx] = 1'b1;
            count_d        = count_q + CNTW'(1);
            status_d       = ST_INSERTED;
            has_slot_d     = 1'b1;
            idx_d          = free_idx;
          end else begin
            status_d   = ST_FULL;
            has_slot_d = 1'b0;
            idx_d      = '0;
          end
        end
        ACT_FORGET: begin
          if (hit_any) begin
            used_d[hit_idx] = 1'b0;
            count_d         = count_q - CNTW'(1);
            status_d        = ST_FORGOTTEN;
            has_slot_d      = 1'b1;
            idx_d           = hit_idx;
          end else begin
            status_d   = ST_NOT_FOUND;
            has_slot_d = 1'b0;
            idx_d      = '0;
          end
        end
        ACT_CLEAR: begin
          used_d     = '0;
          count_d    = '0;
          status_d   = ST_CLEARED;
          has_slot_d = 1'b0;
          idx_d      = '0;
        end
        ACT_QUERY: begin
          status_d   = hit_any ? ST_FOUND : ST_NOT_FOUND;
          has_slot_d = hit_any;
          idx_d      = hit_any ? hit_idx : '0;
        end
        default: begin
          status_d = status_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      count_q    <= '0;
      status_q   <= ST_CLEARED;
      has_slot_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      used_q     <= used_d;
      count_q    <= count_d;
      status_q   <= status_d;
      has_slot_q <= has_slot_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) slot_key_q[free_idx] <= key_q;
  end

  assign is_visual = (sense_q == SENSE_VISUAL);
  assign is_sound  = (sense_q == SENSE_SOUND);

  // a fresh slot gets every field written, so stale contents never show
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[wr_idx]   <= pos_q;
      vel_mem[wr_idx]   <= vel_q;
      dist_mem[wr_idx]  <= dist_q;
      check_mem[wr_idx] <= now_q;
    end
    if (wr_en && (is_visual || wr_ins)) begin
      seen_mem[wr_idx] <= is_visual ? now_q : '0;
    end
    if (wr_en && (is_sound || wr_ins)) begin
      heard_mem[wr_idx] <= is_sound ? now_q : '0;
    end
    if (wr_en && (is_visual || is_sound || wr_ins)) begin
      vis_mem[wr_idx] <= is_visual;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_dist_q  <= dist_mem[idx_q];
      rd_seen_q  <= seen_mem[idx_q];
      rd_heard_q <= heard_mem[idx_q];
      rd_check_q <= check_mem[idx_q];
      rd_vis_q   <= vis_mem[idx_q];
    end
  end

  // a reported slot that is free reads as zeros with the distance at DIST_MAX
  always_comb begin
    status_o         = status_q;
    slot_index_o     = IDX_OUT_W'(idx_q);
    occupied_count_o = CNT_OUT_W'(count_q);
    is_visible_o     = 1'b0;
    seen_time_o      = '0;
    heard_time_o     = '0;
    check_time_o     = '0;
    slot_dist_o      = '0;
    if (has_slot_q) begin
      if (used_q[idx_q]) begin
        is_visible_o = rd_vis_q;
        seen_time_o  = rd_seen_q;
        heard_time_o = rd_heard_q;
        check_time_o = rd_check_q;
        slot_dist_o  = rd_dist_q;
      end else begin
        slot_dist_o  = DIST_MAX;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNTW'($countones(used_q)))
    else $error("occupied count disagrees with slot flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (has_slot_q && (status_q == ST_INSERTED || status_q == ST_UPDATED ||
                    status_q == ST_FOUND)) |-> used_q[idx_q])
    else $error("reported slot is not occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == ST_FULL) |-> (&used_q))
    else $error("full reported with a free slot");

endmodule
`default_nettype wire

// ----- hdl/tracked_entity_slot_table_unit.sv -----
// top level of the tracked entity slot table
// Each request occupies the block through four steps (capture, key match and table
// update, record read, result) and for as long as its result stands stalled; the
// sequence is set by the controller, which holds one request at a time while the
// record memories are written and then read through their single registered read
// port. Keys and occupancy flags sit in flops and are compared in parallel, so no
// clearing pass follows reset and clear all completes in one request.
`timescale 1ns / 1ps
`default_nettype none
module tracked_entity_slot_table_unit #(
  parameter int unsigned NUM_SLOTS = tes_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [tes_pkg::KEY_W-1:0]         entity_id_i,
  input  wire logic [1:0]                        sense_kind_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] pos_x_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] pos_y_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] pos_z_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] vel_x_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] vel_y_i,
  input  wire logic signed [tes_pkg::COORD_W-1:0] vel_z_i,
  input  wire logic [tes_pkg::VAL_W-1:0]         range_dist_i,
  input  wire logic [tes_pkg::VAL_W-1:0]         now_time_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tes_pkg::STATUS_W-1:0]           status_o,
  output logic [tes_pkg::IDX_OUT_W-1:0]          slot_index_o,
  output logic [tes_pkg::CNT_OUT_W-1:0]          occupied_count_o,
  output logic                                   is_visible_o,
  output logic [tes_pkg::VAL_W-1:0]              seen_time_o,
  output logic [tes_pkg::VAL_W-1:0]              heard_time_o,
  output logic [tes_pkg::VAL_W-1:0]              check_time_o,
  output logic [tes_pkg::VAL_W-1:0]              slot_dist_o
);
  import tes_pkg::*;

  tes_cmd_t cmd;

  tes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tes_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .entity_id_i      (entity_id_i),
    .sense_kind_i     (sense_kind_i),
    .pos_i            ({pos_z_i, pos_y_i, pos_x_i}),
    .vel_i            ({vel_z_i, vel_y_i, vel_x_i}),
    .range_dist_i     (range_dist_i),
    .now_time_i       (now_time_i),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .occupied_count_o (occupied_count_o),
    .is_visible_o     (is_visible_o),
    .seen_time_o      (seen_time_o),
    .heard_time_o     (heard_time_o),
    .check_time_o     (check_time_o),
    .slot_dist_o      (slot_dist_o)
  );

endmodule
`default_nettype wire

// ----- bench/tracked_entity_slot_table_unit_tb.sv -----
// testbench for the tracked entity slot table: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tracked_entity_slot_table_unit_tb;
  import tes_pkg::*;

  localparam int unsigned TABLE_SLOTS = NUM_SLOTS_DEF;
  localparam logic [1:0] SENSE_SMELL = 2'd2;
  localparam logic [1:0] SENSE_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned KEY_POOL = 24;

  typedef struct {
    action_e                    act;
    logic [KEY_W-1:0]           id;
    logic [1:0]                 sense;
    logic signed [COORD_W-1:0]  pos [3];
    logic signed [COORD_W-1:0]  vel [3];
    logic [VAL_W-1:0]           distance;
    logic [VAL_W-1:0]           now;
  } request_t;

  typedef struct {
    status_e                st;
    logic [IDX_OUT_W-1:0]   idx;
    logic [CNT_OUT_W-1:0]   cnt;
    logic                   vis;
    logic [VAL_W-1:0]       seen;
    logic [VAL_W-1:0]       heard;
    logic [VAL_W-1:0]       chk;
    logic [VAL_W-1:0]       distance;
  } record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = ACT_QUERY;
  logic [KEY_W-1:0] entity_id_i = '0;
  logic [1:0] sense_kind_i = SENSE_VISUAL;
  logic signed [COORD_W-1:0] pos_x_i = '0;
  logic signed [COORD_W-1:0] pos_y_i = '0;
  logic signed [COORD_W-1:0] pos_z_i = '0;
  logic signed [COORD_W-1:0] vel_x_i = '0;
  logic signed [COORD_W-1:0] vel_y_i = '0;
  logic signed [COORD_W-1:0] vel_z_i = '0;
  logic [VAL_W-1:0] range_dist_i = '0;
  logic [VAL_W-1:0] now_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_OUT_W-1:0] slot_index_o;
  logic [CNT_OUT_W-1:0] occupied_count_o;
  logic is_visible_o;
  logic [VAL_W-1:0] seen_time_o;
  logic [VAL_W-1:0] heard_time_o;
  logic [VAL_W-1:0] check_time_o;
  logic [VAL_W-1:0] slot_dist_o;

  // mirror of the slot table
  logic [KEY_W-1:0] mirror_key [TABLE_SLOTS];
  logic mirror_used [TABLE_SLOTS];
  logic signed [COORD_W-1:0] mirror_pos [TABLE_SLOTS][3];
  logic signed [COORD_W-1:0] mirror_vel [TABLE_SLOTS][3];
  logic [VAL_W-1:0] mirror_dist [TABLE_SLOTS];
  logic [VAL_W-1:0] mirror_seen [TABLE_SLOTS];
  logic [VAL_W-1:0] mirror_heard [TABLE_SLOTS];
  logic [VAL_W-1:0] mirror_check [TABLE_SLOTS];
  logic mirror_visible [TABLE_SLOTS];
  int unsigned mirror_count;

  record_t pending_records [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_request = 0;
  bit idle_on = 1'b1;

  tracked_entity_slot_table_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .entity_id_i      (entity_id_i),
    .sense_kind_i     (sense_kind_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .vel_z_i          (vel_z_i),
    .range_dist_i     (range_dist_i),
    .now_time_i       (now_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .occupied_count_o (occupied_count_o),
    .is_visible_o     (is_visible_o),
    .seen_time_o      (seen_time_o),
    .heard_time_o     (heard_time_o),
    .check_time_o     (check_time_o),
    .slot_dist_o      (slot_dist_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_records.size());
        $display("tracked_entity_slot_table_unit_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic void wipe_mirror_slot(int s);
    mirror_key[s] = '0;
    mirror_used[s] = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mirror_pos[s][i] = '0;
      mirror_vel[s][i] = '0;
    end
    mirror_dist[s] = DIST_MAX;
    mirror_seen[s] = '0;
    mirror_heard[s] = '0;
    mirror_check[s] = '0;
    mirror_visible[s] = 1'b0;
  endfunction

  function automatic void wipe_mirror();
    for (int s = 0; s < TABLE_SLOTS; s++) wipe_mirror_slot(s);
    mirror_count = 0;
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] id);
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      if (mirror_used[s] && mirror_key[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic record_t slot_record(status_e st, int s);
    record_t r;
    r.st = st;
    r.cnt = CNT_OUT_W'(mirror_count);
    if (s < 0) begin
      r.idx = '0;
      r.vis = 1'b0;
      r.seen = '0;
      r.heard = '0;
      r.chk = '0;
      r.distance = '0;
    end else begin
      r.idx = IDX_OUT_W'(s);
      r.vis = mirror_visible[s];
      r.seen = mirror_seen[s];
      r.heard = mirror_heard[s];
      r.chk = mirror_check[s];
      r.distance = mirror_dist[s];
    end
    return r;
  endfunction

  // applies one request to the mirror and returns the record the block reports
  function automatic record_t table_step(request_t q);
    int s;
    status_e st;
    s = find_slot(q.id);
    case (q.act)
      ACT_MEMORIZE: begin
        st = ST_UPDATED;
        if (s < 0) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!mirror_used[i]) begin
              s = i;
              break;
            end
          end
          if (s < 0) return slot_record(ST_FULL, -1);
          mirror_used[s] = 1'b1;
          mirror_key[s] = q.id;
          mirror_count++;
          st = ST_INSERTED;
        end
        for (int i = 0; i < 3; i++) begin
          mirror_pos[s][i] = q.pos[i];
          mirror_vel[s][i] = q.vel[i];
        end
        mirror_dist[s] = q.distance;
        mirror_check[s] = q.now;
        if (q.sense == SENSE_VISUAL) begin
          mirror_seen[s] = q.now;
          mirror_visible[s] = 1'b1;
        end else if (q.sense == SENSE_SOUND) begin
          mirror_heard[s] = q.now;
          mirror_visible[s] = 1'b0;
        end
        return slot_record(st, s);
      end
      ACT_FORGET: begin
        if (s < 0) return slot_record(ST_NOT_FOUND, -1);
        wipe_mirror_slot(s);
        if (mirror_count > 0) mirror_count--;
        return slot_record(ST_FORGOTTEN, s);
      end
      ACT_CLEAR: begin
        wipe_mirror();
        return slot_record(ST_CLEARED, -1);
      end
      default: begin
        return slot_record(s < 0 ? ST_NOT_FOUND : ST_FOUND, s);
      end
    endcase
  endfunction

  function automatic request_t make_request(action_e a, logic [KEY_W-1:0] id,
                                            logic [1:0] sense);
    request_t q;
    q.act = a;
    q.id = id;
    q.sense = sense;
    for (int i = 0; i < 3; i++) begin
      q.pos[i] = $urandom;
      q.vel[i] = $urandom;
    end
    q.distance = VAL_W'($urandom);
    q.now = VAL_W'($urandom);
    return q;
  endfunction

  task automatic send_request(input request_t q);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i <= q.act;
    entity_id_i <= q.id;
    sense_kind_i <= q.sense;
    pos_x_i <= q.pos[0];
    pos_y_i <= q.pos[1];
    pos_z_i <= q.pos[2];
    vel_x_i <= q.vel[0];
    vel_y_i <= q.vel[1];
    vel_z_i <= q.vel[2];
    range_dist_i <= q.distance;
    now_time_i <= q.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_records.push_back(table_step(q));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_records.size() > 0) @(posedge clk_i);
  endtask

  // receiver stall: random bursts while idle_on is set, or one long hold when asked
  initial begin
    int n;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        repeat (n) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 7);
        repeat (n) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        n = $urandom_range(1, 7);
        repeat (n) begin
          out_stall_i <= 1'b0;
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  initial begin
    record_t want;
    bit bad;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_records.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d", $time, status_o);
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          bad = 1'b0;
          bad |= field_differs("status", 32'(want.st), 32'(status_o));
          bad |= field_differs("slot_index", 32'(want.idx), 32'(slot_index_o));
          bad |= field_differs("occupied_count", 32'(want.cnt), 32'(occupied_count_o));
          bad |= field_differs("is_visible", 32'(want.vis), 32'(is_visible_o));
          bad |= field_differs("seen_time", 32'(want.seen), 32'(seen_time_o));
          bad |= field_differs("heard_time", 32'(want.heard), 32'(heard_time_o));
          bad |= field_differs("check_time", 32'(want.chk), 32'(check_time_o));
          bad |= field_differs("slot_dist", 32'(want.distance), 32'(slot_dist_o));
          if (bad) fail_count++;
        end
      end
    end
  end

  task automatic test_sense_updates();
    request_t q;
    logic [KEY_W-1:0] top_id;
    top_id = '1;
    q = make_request(ACT_MEMORIZE, top_id, SENSE_VISUAL);
    for (int i = 0; i < 3; i++) begin
      q.pos[i] = 32'sh7fffffff;
      q.vel[i] = 32'sh80000000;
    end
    q.distance = DIST_MAX;
    q.now = DIST_MAX;
    send_request(q);
    send_request(make_request(ACT_QUERY, top_id, SENSE_VISUAL));
    q = make_request(ACT_MEMORIZE, top_id, SENSE_SOUND);
    for (int i = 0; i < 3; i++) begin
      q.pos[i] = 32'sh80000000;
      q.vel[i] = 32'sh7fffffff;
    end
    q.distance = '0;
    q.now = '0;
    send_request(q);
    send_request(make_request(ACT_MEMORIZE, top_id, SENSE_SMELL));
    send_request(make_request(ACT_MEMORIZE, top_id, SENSE_SPARE));
    send_request(make_request(ACT_QUERY, '0, SENSE_VISUAL));
    send_request(make_request(ACT_FORGET, '0, SENSE_VISUAL));
    send_request(make_request(ACT_MEMORIZE, '0, SENSE_VISUAL));
    send_request(make_request(ACT_FORGET, top_id, SENSE_SOUND));
    send_request(make_request(ACT_QUERY, top_id, SENSE_VISUAL));
    send_request(make_request(ACT_CLEAR, '0, SENSE_VISUAL));
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] ids [TABLE_SLOTS];
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      ids[s] = $urandom;
      send_request(make_request(ACT_MEMORIZE, ids[s], 2'($urandom_range(0, 3))));
    end
    send_request(make_request(ACT_MEMORIZE, ~ids[0], SENSE_VISUAL));
    send_request(make_request(ACT_MEMORIZE, ids[9], SENSE_SOUND));
    send_request(make_request(ACT_FORGET, ids[5], SENSE_VISUAL));
    send_request(make_request(ACT_MEMORIZE, ~ids[0], SENSE_SOUND));
    send_request(make_request(ACT_CLEAR, '0, SENSE_VISUAL));
  endtask

  // mostly keys from a small pool so that hits, misses and a full table all occur
  function automatic request_t random_request();
    int r;
    logic [KEY_W-1:0] id;
    action_e a;
    r = $urandom_range(0, 99);
    if (r < 55) a = ACT_MEMORIZE;
    else if (r < 73) a = ACT_QUERY;
    else if (r < 97) a = ACT_FORGET;
    else a = ACT_CLEAR;
    if ($urandom_range(0, 9) == 0) id = $urandom;
    else id = key_pool[$urandom_range(0, KEY_POOL - 1)];
    return make_request(a, id, 2'($urandom_range(0, 3)));
  endfunction

  task automatic test_random_traffic(int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic test_long_result_hold();
    hold_request = 150;
    repeat (30) send_request(random_request());
  endtask

  task automatic test_sender_pause();
    wait_drained();
    repeat (20) send_request(random_request());
  endtask

  task automatic test_no_idle_tail();
    idle_on = 1'b0;
    repeat (120) send_request(random_request());
  endtask

  initial begin
    wipe_mirror();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sense_updates();
    test_full_table();
    test_random_traffic(380);
    test_long_result_hold();
    test_sender_pause();
    test_no_idle_tail();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tracked_entity_slot_table_unit_tb OK");
    end else begin
      $display("tracked_entity_slot_table_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
